[hw/rtl/hcfm_pkg.sv]
// Shared types and constants for the heightmap cell fan mesher.
// No dependencies.
package hcfm_pkg;

    localparam int CELL_VERTS = 12;
    localparam int VIDX_W     = 4;
    localparam int COORD_W    = 9;
    localparam int CFG_W      = 9;

    typedef enum logic [2:0] {
        CORNER_A,
        CORNER_B,
        CORNER_C,
        CORNER_D,
        CORNER_M
    } corner_t;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] z0;
        logic               mesh_last;
    } cell_pos_t;

    // fan order: A B M A C M C D M B D M
    function automatic corner_t vertex_corner(input logic [VIDX_W-1:0] k);
        corner_t c;
        case (k)
            4'd0, 4'd3:        c = CORNER_A;
            4'd1, 4'd9:        c = CORNER_B;
            4'd4, 4'd6:        c = CORNER_C;
            4'd7, 4'd10:       c = CORNER_D;
            default:           c = CORNER_M;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] corner_u(input corner_t c);
        logic [1:0] u;
        case (c)
            CORNER_A, CORNER_C: u = 2'd0;
            CORNER_B, CORNER_D: u = 2'd2;
            default:            u = 2'd1;
        endcase
        return u;
    endfunction

    function automatic logic [1:0] corner_v(input corner_t c);
        logic [1:0] v;
        case (c)
            CORNER_A, CORNER_B: v = 2'd0;
            CORNER_C, CORNER_D: v = 2'd2;
            default:            v = 2'd1;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/heightmap_cell_fan_mesher.sv]
// Top level: grid counters, column store access, cell emitter and config port.
// Depends on hcfm_pkg, hcfm_column_store, hcfm_cell_emitter.
// Path: a cell-completing sample is registered in stage 1, then loaded into the emitter
// when it is free; output is one vertex per cycle while m_axis_tready is high. Samples
// that complete no cell are taken every cycle unless stage 1 holds a waiting cell.
// Reset: async active low; counters and neighbor samples clear, sizes return to 256;
// column store content is undefined until written, with no clearing pass.
module heightmap_cell_fan_mesher #(
    parameter int MAX_DEPTH   = 256,
    parameter int MAX_WIDTH   = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // config write
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic                                    cfg_index,
    input  logic [hcfm_pkg::CFG_W-1:0]              cfg_data,
    // sample stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0]        s_axis_tdata,  // height_sample
    // vertex stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // x_half, y_height, z_half, u_half, v_half
    output logic [((HEIGHT_BITS+31)/8)*8-1:0]       m_axis_tdata,
    output logic                                    m_axis_tlast,  // cell_last
    output logic                                    m_axis_tuser   // mesh_last
);

    localparam int YW    = HEIGHT_BITS + 2;
    localparam int PAY_W = 2 * hcfm_pkg::COORD_W + YW + 4;
    localparam int OUT_W = ((PAY_W + 7) / 8) * 8;
    localparam int WCW   = $clog2(MAX_WIDTH);
    localparam int DCW   = $clog2(MAX_DEPTH);
    localparam int WXW   = ($clog2(MAX_WIDTH + 1) > hcfm_pkg::CFG_W) ?
                           $clog2(MAX_WIDTH + 1) : hcfm_pkg::CFG_W;
    localparam int DXW   = ($clog2(MAX_DEPTH + 1) > hcfm_pkg::CFG_W) ?
                           $clog2(MAX_DEPTH + 1) : hcfm_pkg::CFG_W;

    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_DEPTH = 1'b1;

    logic [hcfm_pkg::CFG_W-1:0] grid_width_reg, grid_depth_reg;
    logic [WCW-1:0]             col_reg, col_next;
    logic [DCW-1:0]             row_reg, row_next;
    logic [HEIGHT_BITS-1:0]     prev_new_reg, prev_old_reg;

    logic                       s1_valid_reg;
    logic                       s1_cell_reg;
    logic [HEIGHT_BITS-1:0]     s1_h_reg;
    hcfm_pkg::cell_pos_t        s1_pos_reg;

    logic [WXW-1:0]             w_eff, col_x;
    logic [DXW-1:0]             d_eff, row_x;
    logic                       wrap;
    logic [WCW-1:0]             col_cur;
    logic [DCW-1:0]             row_cur;
    logic [WCW-1:0]             col_m1;
    logic [DCW-1:0]             row_m1;
    logic                       in_xfer;
    logic                       s1_adv;
    logic                       emit_load;
    logic                       emit_free;
    logic [HEIGHT_BITS-1:0]     h_in;
    logic [HEIGHT_BITS-1:0]     displaced;
    hcfm_pkg::cell_pos_t        pos_cur;

    logic [hcfm_pkg::COORD_W-1:0] x_half, z_half;
    logic [YW-1:0]                y_height;
    logic [1:0]                   u_half, v_half;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= hcfm_pkg::CFG_W'(256);
            grid_depth_reg <= hcfm_pkg::CFG_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_WIDTH: grid_width_reg <= cfg_data;
                REG_GRID_DEPTH: grid_depth_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_eff = (WXW'(grid_width_reg) < WXW'(MAX_WIDTH)) ?
                   WXW'(grid_width_reg) : WXW'(MAX_WIDTH);
    assign d_eff = (DXW'(grid_depth_reg) < DXW'(MAX_DEPTH)) ?
                   DXW'(grid_depth_reg) : DXW'(MAX_DEPTH);

    // counters restart if a resize left them out of range
    assign wrap    = (WXW'(col_reg) >= w_eff) || (DXW'(row_reg) >= d_eff);
    assign col_cur = wrap ? '0 : col_reg;
    assign row_cur = wrap ? '0 : row_reg;
    assign col_x   = WXW'(col_cur);
    assign row_x   = DXW'(row_cur);
    assign col_m1  = col_cur - 1'b1;
    assign row_m1  = row_cur - 1'b1;

    always_comb
    begin
        col_next = col_cur;
        row_next = row_cur + 1'b1;
        if (row_x + 1'b1 >= d_eff)
        begin
            row_next = '0;
            if (col_x + 1'b1 >= w_eff)
                col_next = '0;
            else
                col_next = col_cur + 1'b1;
        end
    end

    assign pos_cur.x0        = hcfm_pkg::COORD_W'({col_m1, 1'b0});
    assign pos_cur.z0        = hcfm_pkg::COORD_W'({row_m1, 1'b0});
    assign pos_cur.mesh_last = (col_x + 1'b1 == w_eff) && (row_x + 1'b1 == d_eff);

    assign h_in          = s_axis_tdata[HEIGHT_BITS-1:0];
    assign emit_load     = s1_valid_reg && s1_cell_reg && emit_free;
    assign s1_adv        = s1_valid_reg && (!s1_cell_reg || emit_free);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            prev_new_reg <= '0;
            prev_old_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_adv)
            begin
                prev_new_reg <= s1_h_reg;
                prev_old_reg <= displaced;
            end
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_h_reg    <= h_in;
            s1_cell_reg <= (col_cur != '0) && (row_cur != '0);
            s1_pos_reg  <= pos_cur;
        end
    end

    hcfm_column_store #(
        .DEPTH  (MAX_DEPTH),
        .DATA_W (HEIGHT_BITS)
    ) u_store (
        .clk   (clk),
        .en    (in_xfer),
        .addr  (row_cur),
        .wdata (h_in),
        .rdata (displaced)
    );

    hcfm_cell_emitter #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .corner_a  (prev_old_reg),
        .corner_b  (prev_new_reg),
        .corner_c  (displaced),
        .corner_d  (s1_h_reg),
        .pos       (s1_pos_reg),
        .free      (emit_free),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .x_half    (x_half),
        .y_height  (y_height),
        .z_half    (z_half),
        .u_half    (u_half),
        .v_half    (v_half),
        .cell_last (m_axis_tlast),
        .mesh_last (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({v_half, u_half, z_half, y_height, x_half});

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted sample did not reach stage 1");

    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_h_reg) && $stable(displaced))
        else $error("stage 1 lost data while stalled");

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !wrap && !(cfg_valid && cfg_ready)
        && $stable(grid_width_reg) && $stable(grid_depth_reg)
        && (w_eff != '0) && (d_eff != '0)
        |=> (WXW'(col_reg) < w_eff) && (DXW'(row_reg) < d_eff))
        else $error("grid counter out of range");

endmodule

[hw/rtl/hcfm_column_store.sv]
// Previous-column height store: single-port RAM, read-first, registered read.
// Depends on nothing.
module hcfm_column_store #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hcfm_cell_emitter.sv]
// Holds one completed cell and sequences its twelve fan vertices out.
// Depends on hcfm_pkg.
module hcfm_cell_emitter #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [HEIGHT_BITS-1:0]        corner_a,
    input  logic [HEIGHT_BITS-1:0]        corner_b,
    input  logic [HEIGHT_BITS-1:0]        corner_c,
    input  logic [HEIGHT_BITS-1:0]        corner_d,
    input  hcfm_pkg::cell_pos_t           pos,
    output logic                          free,
    output logic                          tvalid,
    input  logic                          tready,
    output logic [hcfm_pkg::COORD_W-1:0]  x_half,
    output logic [HEIGHT_BITS+1:0]        y_height,
    output logic [hcfm_pkg::COORD_W-1:0]  z_half,
    output logic [1:0]                    u_half,
    output logic [1:0]                    v_half,
    output logic                          cell_last,
    output logic                          mesh_last
);

    localparam int YW = HEIGHT_BITS + 2;

    logic                           busy_reg;
    logic [hcfm_pkg::VIDX_W-1:0]    k_reg;
    logic [HEIGHT_BITS-1:0]         a_reg, b_reg, c_reg, d_reg;
    logic [YW-1:0]                  m_reg;
    hcfm_pkg::cell_pos_t            pos_reg;

    logic                           last_vtx;
    logic                           take;
    logic [YW-1:0]                  m_next;
    hcfm_pkg::corner_t              corner;

    assign last_vtx = (k_reg == hcfm_pkg::VIDX_W'(hcfm_pkg::CELL_VERTS - 1));
    assign take     = busy_reg && tready;
    assign free     = !busy_reg || (take && last_vtx);

    assign m_next = {{2{corner_a[HEIGHT_BITS-1]}}, corner_a}
                  + {{2{corner_b[HEIGHT_BITS-1]}}, corner_b}
                  + {{2{corner_c[HEIGHT_BITS-1]}}, corner_c}
                  + {{2{corner_d[HEIGHT_BITS-1]}}, corner_d};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (take)
        begin
            if (last_vtx)
            begin
                busy_reg <= 1'b0;
                k_reg    <= '0;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= corner_a;
            b_reg   <= corner_b;
            c_reg   <= corner_c;
            d_reg   <= corner_d;
            m_reg   <= m_next;
            pos_reg <= pos;
        end
    end

    assign corner = hcfm_pkg::vertex_corner(k_reg);
    assign u_half = hcfm_pkg::corner_u(corner);
    assign v_half = hcfm_pkg::corner_v(corner);

    always_comb
    begin
        case (corner)
            hcfm_pkg::CORNER_A: y_height = {a_reg, 2'b00};
            hcfm_pkg::CORNER_B: y_height = {b_reg, 2'b00};
            hcfm_pkg::CORNER_C: y_height = {c_reg, 2'b00};
            hcfm_pkg::CORNER_D: y_height = {d_reg, 2'b00};
            default:            y_height = m_reg;
        endcase
    end

    assign x_half    = pos_reg.x0 + hcfm_pkg::COORD_W'(u_half);
    assign z_half    = pos_reg.z0 + hcfm_pkg::COORD_W'(v_half);
    assign tvalid    = busy_reg;
    assign cell_last = last_vtx;
    assign mesh_last = last_vtx && pos_reg.mesh_last;

    // a new cell never overwrites one still being sent
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n) load |-> free)
        else $error("cell loaded while emitter busy");

    a_mesh_on_cell_end: assert property (@(posedge clk) disable iff (!rst_n)
        tvalid && mesh_last |-> cell_last)
        else $error("mesh end off a cell end");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !tready |=> busy_reg && $stable(k_reg))
        else $error("vertex index moved during stall");

endmodule
